FILE: src/gds_pkg.sv
// Package: shared constants, types and helpers of the divergence stencil.
`default_nettype none
package gds_pkg;
  localparam int unsigned MAX_X_DEF = 16;
  localparam int unsigned MAX_Y_DEF = 16;
  localparam int unsigned MAX_Z_DEF = 16;

  localparam logic [2:0] REG_GAIN_X = 3'd0;
  localparam logic [2:0] REG_GAIN_Y = 3'd1;
  localparam logic [2:0] REG_GAIN_Z = 3'd2;
  localparam logic [2:0] REG_SIZE_X = 3'd3;
  localparam logic [2:0] REG_SIZE_Y = 3'd4;
  localparam logic [2:0] REG_SIZE_Z = 3'd5;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  // Axis position class: interior, first index, last index.
  typedef enum logic [1:0] {
    POS_MID   = 2'd0,
    POS_FIRST = 2'd1,
    POS_LAST  = 2'd2
  } pos_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic        is_load;
    logic        range_err;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  z;
    pos_t        px;
    pos_t        py;
    pos_t        pz;
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] w;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_RD0   = 3'd1,
    ST_RD1   = 3'd2,
    ST_RD2   = 3'd3,
    ST_MUL   = 3'd4,
    ST_SUM   = 3'd5,
    ST_OUT   = 3'd6
  } bstate_t;

  // Clamp a size register to 3..dim.
  function automatic logic [4:0] eff_size(input logic [4:0] s, input logic [4:0] dim);
    logic [4:0] r;
    r = s;
    if (r < 5'd3) r = 5'd3;
    if (r > dim) r = dim;
    return r;
  endfunction

  function automatic pos_t classify(input logic [3:0] p, input logic [4:0] n);
    pos_t r;
    if (p == 4'd0) r = POS_FIRST;
    else if ({1'b0, p} == n - 5'd1) r = POS_LAST;
    else r = POS_MID;
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/grid_divergence_stencil_core.sv
// Top level: divergence stencil with decoupled front and back.
//  channel | direction | handshake              | fields
//  in      | input     | in_valid / in_ready     | req_type, x/y/z_index, u/v/w_value
//  out     | output    | out_valid / out_ready   | rhs_value, range_error, saturated
//  cfg     | input     | cfg_we (no wait)        | cfg_index, cfg_data
// A load holds the back in RD0 only; a compute steps it through RD0, RD1, RD2,
// MUL, SUM and OUT (RD0 and OUT when an index is out of range), set by the three
// sequential reads of the single-port u/v/w stores and the gain multiply stage.
// The front queue holds two items, so intake continues while the back works.
// Reset (rst, synchronous) restores the registers; the stores are not cleared.
// A stalled result holds the back at its next result; queued items wait in the front.
`default_nettype none
module grid_divergence_stencil_core #(
  parameter int unsigned MAX_X = gds_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y = gds_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z = gds_pkg::MAX_Z_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [3:0]  x_index,
  input  wire logic [3:0]  y_index,
  input  wire logic [3:0]  z_index,
  input  wire logic [31:0] u_value,
  input  wire logic [31:0] v_value,
  input  wire logic [31:0] w_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      rhs_value,
  output logic             range_error,
  output logic             saturated
);
  logic          q_valid, q_ready;
  gds_pkg::cmd_t q_cmd;
  logic [31:0]   gain_x, gain_y, gain_z;

  gds_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .req_type, .x_index, .y_index, .z_index, .u_value, .v_value, .w_value,
    .q_valid, .q_ready, .q_cmd, .gain_x, .gain_y, .gain_z
  );

  gds_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .gain_x, .gain_y, .gain_z,
    .out_valid, .out_ready, .rhs_value, .range_error, .saturated
  );
endmodule
`default_nettype wire

FILE: src/gds_front.sv
// Front: register file, item classification and a two-entry command queue.
`default_nettype none
module gds_front #(
  parameter int unsigned MAX_X = gds_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y = gds_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z = gds_pkg::MAX_Z_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              req_type,
  input  wire logic [3:0]        x_index,
  input  wire logic [3:0]        y_index,
  input  wire logic [3:0]        z_index,
  input  wire logic [31:0]       u_value,
  input  wire logic [31:0]       v_value,
  input  wire logic [31:0]       w_value,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output gds_pkg::cmd_t          q_cmd,
  output logic [31:0]            gain_x,
  output logic [31:0]            gain_y,
  output logic [31:0]            gain_z
);
  localparam int unsigned DX = (MAX_X < 16) ? MAX_X : 16;
  localparam int unsigned DY = (MAX_Y < 16) ? MAX_Y : 16;
  localparam int unsigned DZ = (MAX_Z < 16) ? MAX_Z : 16;
  localparam logic [4:0] DIMX = 5'(DX);
  localparam logic [4:0] DIMY = 5'(DY);
  localparam logic [4:0] DIMZ = 5'(DZ);

  logic [4:0] size_x, size_y, size_z;
  logic [4:0] nx, ny, nz;
  gds_pkg::cmd_t cmd;
  gds_pkg::cmd_t slot [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  logic       keep, push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x <= 32'd65536;
      gain_y <= 32'd65536;
      gain_z <= 32'd65536;
      size_x <= 5'd16;
      size_y <= 5'd16;
      size_z <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        gds_pkg::REG_GAIN_X: gain_x <= cfg_data;
        gds_pkg::REG_GAIN_Y: gain_y <= cfg_data;
        gds_pkg::REG_GAIN_Z: gain_z <= cfg_data;
        gds_pkg::REG_SIZE_X: size_x <= cfg_data[4:0];
        gds_pkg::REG_SIZE_Y: size_y <= cfg_data[4:0];
        gds_pkg::REG_SIZE_Z: size_z <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign nx = gds_pkg::eff_size(size_x, DIMX);
  assign ny = gds_pkg::eff_size(size_y, DIMY);
  assign nz = gds_pkg::eff_size(size_z, DIMZ);

  always_comb begin
    cmd.is_load = (req_type == gds_pkg::REQ_LOAD);
    if (cmd.is_load) begin
      cmd.range_err = ({1'b0, x_index} >= DIMX) || ({1'b0, y_index} >= DIMY) ||
                      ({1'b0, z_index} >= DIMZ);
    end else begin
      cmd.range_err = ({1'b0, x_index} >= nx) || ({1'b0, y_index} >= ny) ||
                      ({1'b0, z_index} >= nz);
    end
    cmd.x  = x_index;
    cmd.y  = y_index;
    cmd.z  = z_index;
    cmd.px = gds_pkg::classify(x_index, nx);
    cmd.py = gds_pkg::classify(y_index, ny);
    cmd.pz = gds_pkg::classify(z_index, nz);
    cmd.u  = u_value;
    cmd.v  = v_value;
    cmd.w  = w_value;
  end

  // Drop loads that fall outside the stores.
  assign keep     = !(cmd.is_load && cmd.range_err);
  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/gds_back.sv
// Back: velocity stores, stencil sequencer, gain multiply, round and saturate.
`default_nettype none
module gds_back #(
  parameter int unsigned MAX_X = gds_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y = gds_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z = gds_pkg::MAX_Z_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  gds_pkg::cmd_t      q_cmd,
  input  wire logic [31:0]   gain_x,
  input  wire logic [31:0]   gain_y,
  input  wire logic [31:0]   gain_z,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        rhs_value,
  output logic               range_error,
  output logic               saturated
);
  localparam int unsigned DX = (MAX_X < 16) ? MAX_X : 16;
  localparam int unsigned DY = (MAX_Y < 16) ? MAX_Y : 16;
  localparam int unsigned DZ = (MAX_Z < 16) ? MAX_Z : 16;
  localparam int unsigned DEPTH = DX * DY * DZ;
  localparam int unsigned AW = $clog2(DEPTH);

  logic [31:0] u_store [DEPTH];
  logic [31:0] v_store [DEPTH];
  logic [31:0] w_store [DEPTH];

  gds_pkg::bstate_t state, state_next;
  gds_pkg::cmd_t    cur;
  logic [AW-1:0]    base;
  logic [AW-1:0]    au, av, aw;
  logic [31:0]      ru, rv, rw;
  logic signed [34:0] dx, dy, dz;
  logic signed [67:0] px, py, pz;
  logic signed [69:0] sum;
  logic signed [69:0] res;
  logic             take, load_wr;

  function automatic logic signed [34:0] sx(input logic [31:0] a);
    return 35'(signed'(a));
  endfunction

  // Tap address for step k (0: centre/near, 1: far side, 2: second neighbour).
  function automatic logic [AW-1:0] tap(input logic [AW-1:0] b, input gds_pkg::pos_t p,
                                        input logic [1:0] k, input int unsigned stride);
    logic [AW-1:0] s;
    logic [AW-1:0] r;
    s = AW'(stride);
    r = b;
    unique case (p)
      gds_pkg::POS_MID:   r = (k == 2'd1) ? b + s : b - s;
      gds_pkg::POS_FIRST: r = (k == 2'd0) ? b : (k == 2'd1) ? b + s : b + s + s;
      gds_pkg::POS_LAST:  r = (k == 2'd0) ? b : (k == 2'd1) ? b - s : b - s - s;
      default:            r = b;
    endcase
    return r;
  endfunction

  assign base = AW'(32'(cur.x) + DX * (32'(cur.y) + DY * 32'(cur.z)));

  logic [1:0] step;
  always_comb begin
    unique case (state)
      gds_pkg::ST_RD1: step = 2'd1;
      gds_pkg::ST_RD2: step = 2'd2;
      default:         step = 2'd0;
    endcase
    au = tap(base, cur.px, step, 1);
    av = tap(base, cur.py, step, DX);
    aw = tap(base, cur.pz, step, DX * DY);
  end

  assign take    = (state == gds_pkg::ST_IDLE) && q_valid;
  assign q_ready = (state == gds_pkg::ST_IDLE);
  assign load_wr = (state == gds_pkg::ST_RD0) && cur.is_load;

  always_ff @(posedge clk) begin
    if (take) cur <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (load_wr) begin
      u_store[base] <= cur.u;
      v_store[base] <= cur.v;
      w_store[base] <= cur.w;
    end
    ru <= u_store[au];
    rv <= v_store[av];
    rw <= w_store[aw];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gds_pkg::ST_IDLE: if (q_valid) state_next = gds_pkg::ST_RD0;
      gds_pkg::ST_RD0: begin
        if (cur.is_load) state_next = gds_pkg::ST_IDLE;
        else if (cur.range_err) state_next = gds_pkg::ST_OUT;
        else state_next = gds_pkg::ST_RD1;
      end
      gds_pkg::ST_RD1: state_next = gds_pkg::ST_RD2;
      gds_pkg::ST_RD2: state_next = gds_pkg::ST_MUL;
      gds_pkg::ST_MUL: state_next = gds_pkg::ST_SUM;
      gds_pkg::ST_SUM: state_next = gds_pkg::ST_OUT;
      // Hold until the output register is free; the item is posted on leaving.
      gds_pkg::ST_OUT: if (!out_valid) state_next = gds_pkg::ST_IDLE;
      default:         state_next = gds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gds_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Accumulate the differences as the registered reads return, in the state after each read.
  function automatic logic signed [34:0] coef(input gds_pkg::pos_t p, input logic [1:0] k,
                                              input logic [31:0] a);
    logic signed [34:0] s;
    logic signed [34:0] r;
    s = sx(a);
    r = '0;
    unique case (p)
      gds_pkg::POS_MID:   r = (k == 2'd1) ? s : (k == 2'd0) ? -s : '0;
      gds_pkg::POS_FIRST: r = (k == 2'd0) ? -(s + s + s) : (k == 2'd1) ? (s <<< 2) : -s;
      gds_pkg::POS_LAST:  r = (k == 2'd0) ? (s + s + s) : (k == 2'd1) ? -(s <<< 2) : s;
      default:            r = '0;
    endcase
    return r;
  endfunction

  logic [1:0] acc_k;
  logic       acc_en;
  always_comb begin
    acc_en = 1'b1;
    unique case (state)
      gds_pkg::ST_RD1: acc_k = 2'd0;
      gds_pkg::ST_RD2: acc_k = 2'd1;
      gds_pkg::ST_MUL: acc_k = 2'd2;
      default: begin
        acc_k  = 2'd0;
        acc_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == gds_pkg::ST_RD0) begin
      dx <= '0;
      dy <= '0;
      dz <= '0;
    end else if (acc_en) begin
      dx <= dx + coef(cur.px, acc_k, ru);
      dy <= dy + coef(cur.py, acc_k, rv);
      dz <= dz + coef(cur.pz, acc_k, rw);
    end
  end

  // Products in Q.16 of the result LSB; gains are unsigned.
  always_ff @(posedge clk) begin
    if (state == gds_pkg::ST_SUM) begin
      px <= 68'(dx) * signed'({36'd0, gain_x});
      py <= 68'(dy) * signed'({36'd0, gain_y});
      pz <= 68'(dz) * signed'({36'd0, gain_z});
    end
  end

  assign sum = 70'(px) + 70'(py) + 70'(pz) + 70'sd32768;
  assign res = sum >>> 16;

  // Load the output register only when it is free.
  always_ff @(posedge clk) begin
    if (state == gds_pkg::ST_OUT && !out_valid) begin
      if (cur.range_err) begin
        rhs_value   <= '0;
        range_error <= 1'b1;
        saturated   <= 1'b0;
      end else begin
        range_error <= 1'b0;
        if (res > 70'sd2147483647) begin
          rhs_value <= 32'h7fffffff;
          saturated <= 1'b1;
        end else if (res < -70'sd2147483648) begin
          rhs_value <= 32'h80000000;
          saturated <= 1'b1;
        end else begin
          rhs_value <= res[31:0];
          saturated <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_valid && out_ready) out_valid <= 1'b0;
    else if (state == gds_pkg::ST_OUT && !out_valid) out_valid <= 1'b1;
  end
endmodule
`default_nettype wire

FILE: src/gds_checker.sv
// Checker: port-level properties of the divergence stencil, bound to the top.
`default_nettype none
module gds_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] rhs_value,
  input wire logic        range_error,
  input wire logic        saturated
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rhs_value))
    else $error("result dropped while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> rhs_value == 32'd0 && !saturated)
    else $error("range error with nonzero value");
  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> rhs_value == 32'h7fffffff || rhs_value == 32'h80000000)
    else $error("saturated without clipped value");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind grid_divergence_stencil_core gds_checker u_gds_checker (
  .clk, .rst, .out_valid, .out_ready, .rhs_value, .range_error, .saturated
);
`default_nettype wire

FILE: tb/sv/grid_divergence_stencil_core_test.sv
// Testbench of the divergence stencil: random loads and computes checked against a predictor.
`default_nettype none
module grid_divergence_stencil_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gds_pkg::*;

  localparam int DIM = 16;

  typedef struct {
    logic        kind;
    logic [3:0]  xi, yi, zi;
    logic [31:0] u, v, w;
  } grid_item_t;

  typedef struct {
    logic [31:0] rhs;
    logic        rerr;
    logic        sat;
  } div_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_GAIN_X;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_LOAD;
  logic [3:0]  x_index = '0, y_index = '0, z_index = '0;
  logic [31:0] u_value = '0, v_value = '0, w_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] rhs_value;
  logic        range_error, saturated;

  grid_divergence_stencil_core dut (.*);

  always #5 clk = ~clk;

  grid_item_t  pend_q[$];
  div_result_t rhs_q[$];
  int          errors = 0;
  int          idle_pct = 0, stall_pct = 0;

  // predictor state
  logic [31:0] u_mem[DIM*DIM*DIM];
  logic [31:0] v_mem[DIM*DIM*DIM];
  logic [31:0] w_mem[DIM*DIM*DIM];
  logic [31:0] gain[3];
  logic [4:0]  size_reg[3];
  // points that the stimulus has already loaded
  bit          loaded[DIM*DIM*DIM];

  function automatic int unsigned clamp_size(logic [4:0] s);
    if (s < 5'd3) return 3;
    if (s > DIM) return DIM;
    return s;
  endfunction

  function automatic longint word_at(int axis, int a);
    case (axis)
      0: return longint'($signed(u_mem[a]));
      1: return longint'($signed(v_mem[a]));
      default: return longint'($signed(w_mem[a]));
    endcase
  endfunction

  function automatic longint axis_slope(int axis, int a, int p, int n);
    int s;
    s = (axis == 0) ? 1 : (axis == 1) ? DIM : DIM * DIM;
    if (p == 0)
      return -3 * word_at(axis, a) + 4 * word_at(axis, a + s) - word_at(axis, a + 2 * s);
    if (p == n - 1)
      return 3 * word_at(axis, a) - 4 * word_at(axis, a - s) + word_at(axis, a - 2 * s);
    return word_at(axis, a + s) - word_at(axis, a - s);
  endfunction

  function automatic div_result_t divergence(grid_item_t it);
    div_result_t r;
    int          pos[3];
    int          n[3];
    int          a;
    longint      d, hi, lo, sum;
    pos[0] = it.xi; pos[1] = it.yi; pos[2] = it.zi;
    r = '{32'd0, 1'b0, 1'b0};
    for (int k = 0; k < 3; k++) n[k] = clamp_size(size_reg[k]);
    if (pos[0] >= n[0] || pos[1] >= n[1] || pos[2] >= n[2]) begin
      r.rerr = 1'b1;
      return r;
    end
    a = pos[0] + DIM * (pos[1] + DIM * pos[2]);
    hi = 0;
    lo = 0;
    for (int k = 0; k < 3; k++) begin
      d = axis_slope(k, a, pos[k], n[k]);
      hi += d * longint'(gain[k][31:16]);
      lo += d * longint'(gain[k][15:0]);
    end
    sum = hi + ((lo + 32768) >>> 16);
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      r.sat = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.rhs = sum[31:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_velocity();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097151)) - 1048576);
      2: case ($urandom_range(3))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0000_0000;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return 32'($signed($urandom_range(33554431)) - 16777216);
    endcase
  endfunction

  task automatic queue_load(int x, int y, int z, logic [31:0] u, logic [31:0] v,
                            logic [31:0] w);
    pend_q.push_back('{REQ_LOAD, 4'(x), 4'(y), 4'(z), u, v, w});
    loaded[x + DIM * (y + DIM * z)] = 1'b1;
  endtask

  task automatic fill_point(int x, int y, int z);
    if (!loaded[x + DIM * (y + DIM * z)])
      queue_load(x, y, z, pick_velocity(), pick_velocity(), pick_velocity());
  endtask

  // Load every stencil neighbor not yet written, then ask for the divergence.
  task automatic queue_compute(int x, int y, int z);
    int n[3];
    int p[3];
    int q[3];
    for (int k = 0; k < 3; k++) n[k] = clamp_size(size_reg[k]);
    p[0] = x; p[1] = y; p[2] = z;
    if (x < n[0] && y < n[1] && z < n[2]) begin
      fill_point(x, y, z);
      for (int k = 0; k < 3; k++) begin
        for (int off = -2; off <= 2; off++) begin
          q = p;
          q[k] = p[k] + off;
          if (off != 0 && q[k] >= 0 && q[k] < n[k])
            if ((p[k] == 0 && off > 0) || (p[k] == n[k] - 1 && off < 0) ||
                (off == 1 || off == -1))
              fill_point(q[0], q[1], q[2]);
        end
      end
    end
    pend_q.push_back('{REQ_COMPUTE, 4'(x), 4'(y), 4'(z), $urandom, $urandom, $urandom});
  endtask

  // driver
  always @(posedge clk) begin
    grid_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (req_type == REQ_LOAD) begin
          u_mem[x_index + DIM * (y_index + DIM * z_index)] = u_value;
          v_mem[x_index + DIM * (y_index + DIM * z_index)] = v_value;
          w_mem[x_index + DIM * (y_index + DIM * z_index)] = w_value;
        end else begin
          rhs_q.push_back(divergence('{req_type, x_index, y_index, z_index,
                                       u_value, v_value, w_value}));
        end
      end
      if (!in_valid || in_ready) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          it = pend_q.pop_front();
          in_valid <= 1'b1;
          req_type <= it.kind;
          x_index <= it.xi;
          y_index <= it.yi;
          z_index <= it.zi;
          u_value <= it.u;
          v_value <= it.v;
          w_value <= it.w;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    div_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rhs_q.size() == 0) begin
          $error("unexpected item: rhs_value %h range_error %b saturated %b",
                 rhs_value, range_error, saturated);
          errors++;
        end else begin
          e = rhs_q.pop_front();
          if (rhs_value !== e.rhs) begin
            $error("rhs_value: expected %h, got %h", e.rhs, rhs_value);
            errors++;
          end
          if (range_error !== e.rerr) begin
            $error("range_error: expected %b, got %b", e.rerr, range_error);
            errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated: expected %b, got %b", e.sat, saturated);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic drain();
    while (pend_q.size() != 0 || in_valid || rhs_q.size() != 0) @(posedge clk);
    // loads leave no result; let the back finish
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx <= REG_GAIN_Z) gain[idx] = data;
    else size_reg[idx - REG_SIZE_X] = data[4:0];
  endtask

  task automatic set_config(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                            logic [4:0] sx, logic [4:0] sy, logic [4:0] sz);
    write_reg(REG_GAIN_X, gx);
    write_reg(REG_GAIN_Y, gy);
    write_reg(REG_GAIN_Z, gz);
    write_reg(REG_SIZE_X, {$urandom_range(1) ? 27'($urandom) : 27'd0, sx});
    write_reg(REG_SIZE_Y, {27'd0, sy});
    write_reg(REG_SIZE_Z, {$urandom_range(1) ? 27'($urandom) : 27'd0, sz});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 55)
        queue_compute($urandom_range(15), $urandom_range(15), $urandom_range(15));
      else
        queue_load($urandom_range(15), $urandom_range(15), $urandom_range(15),
                   pick_velocity(), pick_velocity(), pick_velocity());
    end
  endtask

  initial begin
    #20ms;
    $display("grid_divergence_stencil_core_test: done, errors");
    $finish;
  end

  initial begin
    for (int k = 0; k < 3; k++) begin
      gain[k] = 32'h0001_0000;
      size_reg[k] = 5'd16;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, interior, edges, out of range, saturation
    queue_compute(0, 0, 0);
    queue_compute(15, 15, 15);
    queue_compute(7, 8, 9);
    queue_compute(0, 15, 7);
    queue_load(1, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_load(2, 2, 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_compute(2, 1, 1);
    queue_compute(1, 2, 2);
    drain();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd3, 5'd4, 5'd5);
    queue_load(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_load(1, 0, 0, 32'h7FFF_FFFF, 32'h0, 32'h0);
    queue_compute(0, 0, 0);
    queue_compute(2, 3, 4);
    queue_compute(3, 0, 0);
    queue_compute(0, 4, 0);
    queue_compute(0, 0, 5);
    queue_compute(15, 15, 15);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      case (ph)
        0: set_config(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 5'd16, 5'd16, 5'd16);
        1: set_config(32'd0, 32'd0, 32'd0, 5'd0, 5'd31, 5'd2);
        2: set_config($urandom, $urandom, $urandom, 5'd17, 5'd1, 5'd16);
        3: set_config(32'h0000_8000, 32'h0003_0000, 32'h0000_0001, 5'd8, 5'd3, 5'd12);
        default: set_config($urandom_range(1) ? $urandom : $urandom_range(262143),
                            $urandom_range(262143), $urandom,
                            5'($urandom_range(31)), 5'($urandom_range(31)),
                            5'($urandom_range(31)));
      endcase
      random_items(16);
      drain();
    end

    if (errors == 0)
      $display("grid_divergence_stencil_core_test: done, clean");
    else
      $display("grid_divergence_stencil_core_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
src/gds_pkg.sv
src/gds_front.sv
src/gds_back.sv
src/grid_divergence_stencil_core.sv
src/gds_checker.sv
tb/sv/grid_divergence_stencil_core_test.sv
